@@ hw/rtl/aadm_pkg.sv @@
// ----------------------------------------------------------------------------
// Analog axis dead-zone mapper package
// Shared widths, calibration constants, register codes and stage structs.
// ----------------------------------------------------------------------------
package aadm_pkg;

   localparam int SAMPLE_BITS_DEF = 12;
   localparam int LEVEL_BITS      = 12;
   localparam int CSR_IDX_BITS    = 3;
   localparam int CSR_DATA_BITS   = LEVEL_BITS;
   localparam int PCT_BITS        = 8;
   // quotient of (d * 100) / span with d < span stays below 100
   localparam int QUOT_BITS       = 7;
   // guard bits so level differences and band constants compare without wrap
   localparam int EXT_BITS        = 3;

   localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 12'd2047;

   localparam int JOY_CENTRE_BAND = 250;
   localparam int JOY_END_BAND    = 150;
   localparam int TRIG_LOW_BAND   = 200;
   localparam int TRIG_HIGH_BAND  = 350;

   localparam logic [PCT_BITS-1:0] PCT_FULL = 8'd100;
   localparam logic [PCT_BITS-1:0] PCT_ZERO = 8'd0;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_HOME   = 3'd0,
      CSR_LOW    = 3'd1,
      CSR_HIGH   = 3'd2,
      CSR_INVERT = 3'd3,
      CSR_MODE   = 3'd4
   } aadm_csr_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] home;
      logic [LEVEL_BITS-1:0] low;
      logic [LEVEL_BITS-1:0] high;
      logic                  invert;
      logic                  one_sided;
   } aadm_cfg_type;

   // result = base + (neg ? -quotient : quotient)
   typedef struct packed {
      logic                neg;
      logic [PCT_BITS-1:0] base;
      logic                cal;
   } aadm_ctl_type;

endpackage

@@ hw/rtl/aadm_if.sv @@
// ----------------------------------------------------------------------------
// Analog axis dead-zone mapper channels
// Request channel (raw sample) and response channel (percent, calibrated).
// ----------------------------------------------------------------------------
interface aadm_req_if #(
   parameter int SAMPLE_BITS = aadm_pkg::SAMPLE_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface aadm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [aadm_pkg::PCT_BITS-1:0] percent;
   logic                          calibrated;

   modport source (output valid, output percent, output calibrated, input ready);
   modport sink   (input valid, input percent, input calibrated, output ready);
endinterface

@@ hw/rtl/aadm_front.sv @@
// ----------------------------------------------------------------------------
// Mapper front end
// Three stages: level differences, band decode and select, scale by 100.
// ----------------------------------------------------------------------------
module aadm_front #(
   parameter int SAMPLE_BITS = aadm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  aadm_pkg::aadm_cfg_type                 cfg,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [SAMPLE_BITS-1:0]                 in_sample,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [SAMPLE_BITS+aadm_pkg::QUOT_BITS-1:0] out_num,
   output logic [SAMPLE_BITS-1:0]                 out_span,
   output aadm_pkg::aadm_ctl_type                 out_ctl
);
   import aadm_pkg::*;

   localparam int W  = SAMPLE_BITS;
   localparam int LW = SAMPLE_BITS + EXT_BITS;
   localparam int NW = SAMPLE_BITS + QUOT_BITS;

   localparam logic signed [LW-1:0] C_TL      = LW'(TRIG_LOW_BAND);
   localparam logic signed [LW-1:0] C_TH_NEG  = LW'(-TRIG_HIGH_BAND);
   localparam logic signed [LW-1:0] C_TSPAN   = LW'(TRIG_LOW_BAND + TRIG_HIGH_BAND);
   localparam logic signed [LW-1:0] C_JC      = LW'(JOY_CENTRE_BAND);
   localparam logic signed [LW-1:0] C_JC_NEG  = LW'(-JOY_CENTRE_BAND);
   localparam logic signed [LW-1:0] C_JE      = LW'(JOY_END_BAND);
   localparam logic signed [LW-1:0] C_JE_NEG  = LW'(-JOY_END_BAND);
   localparam logic signed [LW-1:0] C_JSPAN   = LW'(JOY_CENTRE_BAND + JOY_END_BAND);

   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic              s1_en, s2_en, s3_en;

   logic [W-1:0]      home_w, low_w, high_w;
   logic signed [LW-1:0] xs, hs, ls, his;
   logic signed [LW-1:0] dxh_in, dxl_in, dxhi_in, sh_in, sl_in;
   logic signed [LW-1:0] dxh_ff, dxl_ff, dxhi_ff, sh_ff, sl_ff;

   logic signed [LW-1:0] d_full, span_full;
   logic [PCT_BITS-1:0]  pct_lo, pct_hi;
   aadm_ctl_type         ctl_in;
   logic [W-1:0]         d_ff, span2_ff;
   aadm_ctl_type         ctl2_ff;

   logic [NW-1:0]        num_in;
   logic [NW-1:0]        num_ff;
   logic [W-1:0]         span3_ff;
   aadm_ctl_type         ctl3_ff;

   // advance a stage when it is empty or its content moves on
   assign s3_en    = !s3_valid_ff || out_ready;
   assign s2_en    = !s2_valid_ff || s3_en;
   assign s1_en    = !s1_valid_ff || s2_en;
   assign in_ready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_en) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // stage 1: differences of the sample and calibration levels
   assign home_w  = W'(cfg.home);
   assign low_w   = W'(cfg.low);
   assign high_w  = W'(cfg.high);
   assign xs      = LW'(in_sample);
   assign hs      = LW'(home_w);
   assign ls      = LW'(low_w);
   assign his     = LW'(high_w);
   assign dxh_in  = xs - hs;
   assign dxl_in  = xs - ls;
   assign dxhi_in = xs - his;
   assign sh_in   = his - hs;
   assign sl_in   = hs - ls;

   always_ff @(posedge clock) begin
      if (s1_en) begin
         dxh_ff  <= dxh_in;
         dxl_ff  <= dxl_in;
         dxhi_ff <= dxhi_in;
         sh_ff   <= sh_in;
         sl_ff   <= sl_in;
      end
   end

   // stage 2: pick the band; constant bands get d = 0 so the quotient is 0
   assign pct_lo = cfg.invert ? PCT_FULL : -PCT_FULL;
   assign pct_hi = cfg.invert ? -PCT_FULL : PCT_FULL;

   always_comb begin
      d_full      = '0;
      span_full   = LW'(1);
      ctl_in.neg  = cfg.invert;
      ctl_in.base = PCT_ZERO;
      ctl_in.cal  = 1'b0;
      if (cfg.one_sided) begin
         ctl_in.cal = sh_ff > C_TSPAN;
         if (dxh_ff <= C_TL) begin
            ctl_in.base = cfg.invert ? PCT_FULL : PCT_ZERO;
         end else if (dxhi_ff >= C_TH_NEG) begin
            ctl_in.base = cfg.invert ? PCT_ZERO : PCT_FULL;
         end else begin
            d_full      = dxh_ff - C_TL;
            span_full   = sh_ff - C_TSPAN;
            ctl_in.base = cfg.invert ? PCT_FULL : PCT_ZERO;
         end
      end else begin
         ctl_in.cal = (sl_ff > C_JSPAN) && (sh_ff > C_JSPAN);
         if ((dxh_ff >= C_JC_NEG) && (dxh_ff <= C_JC)) begin
            ctl_in.base = PCT_ZERO;
         end else if (dxl_ff <= C_JE) begin
            ctl_in.base = pct_lo;
         end else if (dxhi_ff >= C_JE_NEG) begin
            ctl_in.base = pct_hi;
         end else if (dxh_ff[LW-1]) begin
            d_full      = dxl_ff - C_JE;
            span_full   = sl_ff - C_JSPAN;
            ctl_in.base = pct_lo;
         end else begin
            d_full      = dxh_ff - C_JC;
            span_full   = sh_ff - C_JSPAN;
            ctl_in.base = PCT_ZERO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         d_ff     <= d_full[W-1:0];
         span2_ff <= span_full[W-1:0];
         ctl2_ff  <= ctl_in;
      end
   end

   // stage 3: d * 100 as 64 + 32 + 4
   assign num_in = NW'({d_ff, 6'b0}) + NW'({d_ff, 5'b0}) + NW'({d_ff, 2'b0});

   always_ff @(posedge clock) begin
      if (s3_en) begin
         num_ff   <= num_in;
         span3_ff <= span2_ff;
         ctl3_ff  <= ctl2_ff;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_num   = num_ff;
   assign out_span  = span3_ff;
   assign out_ctl   = ctl3_ff;

endmodule

@@ hw/rtl/aadm_div_stage.sv @@
// ----------------------------------------------------------------------------
// Mapper divider stage
// One restoring step: resolves quotient bit BIT of (d * 100) / span.
// ----------------------------------------------------------------------------
module aadm_div_stage #(
   parameter int SAMPLE_BITS = aadm_pkg::SAMPLE_BITS_DEF,
   parameter int BIT         = 0
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   output logic                                       in_ready,
   input  logic [SAMPLE_BITS+aadm_pkg::QUOT_BITS-1:0] in_rem,
   input  logic [SAMPLE_BITS-1:0]                     in_span,
   input  logic [aadm_pkg::QUOT_BITS-1:0]             in_quot,
   input  aadm_pkg::aadm_ctl_type                     in_ctl,
   output logic                                       out_valid,
   input  logic                                       out_ready,
   output logic [SAMPLE_BITS+aadm_pkg::QUOT_BITS-1:0] out_rem,
   output logic [SAMPLE_BITS-1:0]                     out_span,
   output logic [aadm_pkg::QUOT_BITS-1:0]             out_quot,
   output aadm_pkg::aadm_ctl_type                     out_ctl
);
   import aadm_pkg::*;

   localparam int NW = SAMPLE_BITS + QUOT_BITS;

   logic                    valid_ff;
   logic                    en;
   logic [NW-1:0]           trial;
   logic                    fits;
   logic [NW-1:0]           rem_in, rem_ff;
   logic [QUOT_BITS-1:0]    quot_in, quot_ff;
   logic [SAMPLE_BITS-1:0]  span_ff;
   aadm_ctl_type            ctl_ff;

   assign en       = !valid_ff || out_ready;
   assign in_ready = en;

   assign trial   = NW'(in_span) << BIT;
   assign fits    = in_rem >= trial;
   assign rem_in  = fits ? (in_rem - trial) : in_rem;
   assign quot_in = in_quot | (QUOT_BITS'(fits) << BIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
         span_ff <= in_span;
         ctl_ff  <= in_ctl;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_span  = span_ff;
   assign out_quot  = quot_ff;
   assign out_ctl   = ctl_ff;

endmodule

@@ hw/rtl/aadm_back.sv @@
// ----------------------------------------------------------------------------
// Mapper back end
// Applies the signed quotient to the band base and holds the response.
// ----------------------------------------------------------------------------
module aadm_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [aadm_pkg::QUOT_BITS-1:0] in_quot,
   input  aadm_pkg::aadm_ctl_type         in_ctl,
   aadm_rsp_if.source                     rsp_chan
);
   import aadm_pkg::*;

   logic                valid_ff;
   logic                en;
   logic [PCT_BITS-1:0] step;
   logic [PCT_BITS-1:0] percent_in, percent_ff;
   logic                cal_ff;

   assign en       = !valid_ff || rsp_chan.ready;
   assign in_ready = en;

   assign step       = PCT_BITS'(in_quot);
   assign percent_in = in_ctl.neg ? (in_ctl.base - step) : (in_ctl.base + step);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         percent_ff <= percent_in;
         cal_ff     <= in_ctl.cal;
      end
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.percent    = percent_ff;
   assign rsp_chan.calibrated = cal_ff;

endmodule

@@ hw/rtl/analog_axis_deadzone_mapper_unit.sv @@
// ----------------------------------------------------------------------------
// Analog axis dead-zone mapper
// Maps a raw ADC sample to a percent position using calibration registers.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  req_chan  in   valid/ready    sample[SAMPLE_BITS]
//  rsp_chan  out  valid/ready    percent[8] (signed), calibrated
//  csr_*     in   csr_we         csr_index[3], csr_wdata[12]
//
//  One request per cycle unless the response side stalls. Three front stages,
//  seven divider stages (one quotient bit each), one response register.
//  Reset clears every stage valid bit and loads the calibration defaults.
//  On a stall each stage holds while its successor is full; empty stages
//  keep filling, so requests are taken until the whole pipe is full.
// ----------------------------------------------------------------------------
module analog_axis_deadzone_mapper_unit #(
   parameter int SAMPLE_BITS = aadm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   aadm_req_if.sink                           req_chan,
   aadm_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [aadm_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [aadm_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import aadm_pkg::*;

   localparam int NW = SAMPLE_BITS + QUOT_BITS;

   aadm_cfg_type          cfg_ff;

   logic                  valid_w [QUOT_BITS+1];
   logic                  ready_w [QUOT_BITS+1];
   logic [NW-1:0]         rem_w   [QUOT_BITS+1];
   logic [SAMPLE_BITS-1:0] span_w [QUOT_BITS+1];
   logic [QUOT_BITS-1:0]  quot_w  [QUOT_BITS+1];
   aadm_ctl_type          ctl_w   [QUOT_BITS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.home      <= LEVEL_RESET;
         cfg_ff.low       <= LEVEL_RESET;
         cfg_ff.high      <= LEVEL_RESET;
         cfg_ff.invert    <= 1'b0;
         cfg_ff.one_sided <= 1'b0;
      end else if (csr_we) begin
         case (aadm_csr_type'(csr_index))
            CSR_HOME: begin
               cfg_ff.home <= csr_wdata;
            end
            CSR_LOW: begin
               cfg_ff.low <= csr_wdata;
            end
            CSR_HIGH: begin
               cfg_ff.high <= csr_wdata;
            end
            CSR_INVERT: begin
               cfg_ff.invert <= csr_wdata[0];
            end
            CSR_MODE: begin
               cfg_ff.one_sided <= csr_wdata[0];
            end
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   aadm_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_sample (req_chan.sample),
      .out_valid (valid_w[0]),
      .out_ready (ready_w[0]),
      .out_num   (rem_w[0]),
      .out_span  (span_w[0]),
      .out_ctl   (ctl_w[0])
   );

   assign quot_w[0] = '0;

   for (genvar i = 0; i < QUOT_BITS; i++) begin : g_div
      aadm_div_stage #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .BIT         (QUOT_BITS - 1 - i)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_w[i]),
         .in_ready  (ready_w[i]),
         .in_rem    (rem_w[i]),
         .in_span   (span_w[i]),
         .in_quot   (quot_w[i]),
         .in_ctl    (ctl_w[i]),
         .out_valid (valid_w[i+1]),
         .out_ready (ready_w[i+1]),
         .out_rem   (rem_w[i+1]),
         .out_span  (span_w[i+1]),
         .out_quot  (quot_w[i+1]),
         .out_ctl   (ctl_w[i+1])
      );
   end

   aadm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (valid_w[QUOT_BITS]),
      .in_ready (ready_w[QUOT_BITS]),
      .in_quot  (quot_w[QUOT_BITS]),
      .in_ctl   (ctl_w[QUOT_BITS]),
      .rsp_chan (rsp_chan)
   );

endmodule

@@ hw/rtl/aadm_checker.sv @@
// ----------------------------------------------------------------------------
// Mapper port checker
// Watches the response channel for range, reset and stall behavior.
// ----------------------------------------------------------------------------
module aadm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [aadm_pkg::PCT_BITS-1:0] rsp_percent,
   input logic                          rsp_calibrated
);
   import aadm_pkg::*;

   // no response may survive a reset cycle
   a_reset_clears : assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // percent never leaves -100..100
   a_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_percent) >= -8'sd100) && ($signed(rsp_percent) <= 8'sd100))
      else $error("percent out of range");

   a_hold_valid : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_hold_data : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_percent) && $stable(rsp_calibrated))
      else $error("response payload changed while stalled");

endmodule

bind analog_axis_deadzone_mapper_unit aadm_checker u_aadm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_percent    (rsp_chan.percent),
   .rsp_calibrated (rsp_chan.calibrated)
);

@@ dv/analog_axis_deadzone_mapper_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Analog axis dead-zone mapper testbench
// Drives raw samples through the request channel under several calibrations,
// idle patterns and a long response hold-off. A scoreboard predicts percent
// and calibrated for every accepted request and checks the responses in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module analog_axis_deadzone_mapper_unit_tb;
   import aadm_pkg::*;

   localparam int SAMPLE_BITS  = 12;
   localparam int PIPE_LATENCY = 11;
   localparam int HOLD_CYCLES  = 120;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;

   typedef struct packed {
      logic signed [PCT_BITS-1:0] percent;
      logic                       calibrated;
   } axis_result_type;

   class deadzone_scoreboard;
      logic [LEVEL_BITS-1:0] home;
      logic [LEVEL_BITS-1:0] low;
      logic [LEVEL_BITS-1:0] high;
      bit                    invert;
      bit                    one_sided;
      axis_result_type       expected_q[$];
      int                    mismatches;
      int                    requests;
      int                    responses;

      function new();
         home = LEVEL_RESET;
         low = LEVEL_RESET;
         high = LEVEL_RESET;
         invert = 1'b0;
         one_sided = 1'b0;
         mismatches = 0;
         requests = 0;
         responses = 0;
      endfunction

      function void apply_csr(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_HOME:   home = data[LEVEL_BITS-1:0];
            CSR_LOW:    low = data[LEVEL_BITS-1:0];
            CSR_HIGH:   high = data[LEVEL_BITS-1:0];
            CSR_INVERT: invert = data[0];
            CSR_MODE:   one_sided = data[0];
            default: ;
         endcase
      endfunction

      function int interpolate(int x, int a, int b, int out_a, int out_b);
         if (b - a <= 0)
            return out_a;
         return ((x - a) * (out_b - out_a)) / (b - a) + out_a;
      endfunction

      function axis_result_type map_sample(logic [SAMPLE_BITS-1:0] raw);
         int x;
         int h;
         int lo;
         int hi;
         int out_min;
         int out_max;
         int out_mid;
         int tmp;
         int res;
         bit cal;
         axis_result_type r;
         x = raw;
         h = home;
         lo = low;
         hi = high;
         out_min = one_sided ? 0 : -100;
         out_max = 100;
         if (invert) begin
            tmp = out_min;
            out_min = out_max;
            out_max = tmp;
         end
         if (one_sided) begin
            if (x <= h + TRIG_LOW_BAND)
               res = out_min;
            else if (x >= hi - TRIG_HIGH_BAND)
               res = out_max;
            else
               res = interpolate(x, h + TRIG_LOW_BAND, hi - TRIG_HIGH_BAND, out_min, out_max);
            cal = (h + TRIG_LOW_BAND + TRIG_HIGH_BAND < hi);
         end else begin
            out_mid = (out_max - out_min) / 2 + out_min;
            if (x + JOY_CENTRE_BAND >= h && x <= h + JOY_CENTRE_BAND)
               res = out_mid;
            else if (x <= lo + JOY_END_BAND)
               res = out_min;
            else if (x + JOY_END_BAND >= hi)
               res = out_max;
            else if (x < h)
               res = interpolate(x, lo + JOY_END_BAND, h - JOY_CENTRE_BAND, out_min, out_mid);
            else
               res = interpolate(x, h + JOY_CENTRE_BAND, hi - JOY_END_BAND, out_mid, out_max);
            cal = (lo + JOY_END_BAND + JOY_CENTRE_BAND < h) &&
                  (h + JOY_CENTRE_BAND + JOY_END_BAND < hi);
         end
         r.percent = res[PCT_BITS-1:0];
         r.calibrated = cal;
         return r;
      endfunction

      function void note_request(logic [SAMPLE_BITS-1:0] raw);
         expected_q.push_back(map_sample(raw));
         requests++;
      endfunction

      function void check_response(logic [PCT_BITS-1:0] percent, logic calibrated);
         axis_result_type exp_r;
         responses++;
         if (expected_q.size() == 0) begin
            $error("response with no request pending: percent %0d calibrated %0b",
                   $signed(percent), calibrated);
            mismatches++;
            return;
         end
         exp_r = expected_q.pop_front();
         if (percent !== exp_r.percent) begin
            $error("percent mismatch: expected %0d, actual %0d",
                   exp_r.percent, $signed(percent));
            mismatches++;
         end
         if (calibrated !== exp_r.calibrated) begin
            $error("calibrated mismatch: expected %0b, actual %0b",
                   exp_r.calibrated, calibrated);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   aadm_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_chan ();
   aadm_rsp_if rsp_chan ();

   analog_axis_deadzone_mapper_unit #(.SAMPLE_BITS(SAMPLE_BITS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   deadzone_scoreboard sb = new();

   int  send_idle_pct;
   int  rsp_stall_pct;
   bit  hold_toggle;
   int  cal_count;
   int  cycle_count = 0;

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off each time hold_toggle flips
   always @(posedge clock) begin : receiver
      static bit last_toggle = 1'b0;
      static int hold_left = 0;
      if (hold_toggle != last_toggle) begin
         last_toggle = hold_toggle;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            sb.note_request(req_chan.sample);
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_response(rsp_chan.percent, rsp_chan.calibrated);
      end
   end

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.apply_csr(idx, data);
   endtask

   // one-bit registers get random upper bits, which the block must drop
   task automatic program_cal(input logic [LEVEL_BITS-1:0] h, input logic [LEVEL_BITS-1:0] l,
                              input logic [LEVEL_BITS-1:0] g, input bit inv, input bit mode);
      logic [CSR_DATA_BITS-1:0] noise;
      noise = CSR_DATA_BITS'($urandom);
      write_csr(CSR_HOME, h);
      write_csr(CSR_LOW, l);
      write_csr(CSR_HIGH, g);
      write_csr(CSR_INVERT, {noise[CSR_DATA_BITS-1:1], inv});
      noise = CSR_DATA_BITS'($urandom);
      write_csr(CSR_MODE, {noise[CSR_DATA_BITS-1:1], mode});
      if ($urandom_range(2) == 0)
         write_csr(CSR_IDX_BITS'(CSR_MODE + 1 + $urandom_range(2)),
                   CSR_DATA_BITS'($urandom));
      csr_we <= 1'b0;
      cal_count++;
   endtask

   task automatic program_random_cal();
      logic [LEVEL_BITS-1:0] h;
      logic [LEVEL_BITS-1:0] l;
      logic [LEVEL_BITS-1:0] g;
      logic [LEVEL_BITS-1:0] picks [3];
      bit                    mode;
      picks = '{12'd0, 12'd2047, 12'd4095};
      mode = 1'($urandom_range(1));
      case ($urandom_range(3))
         0: begin
            l = LEVEL_BITS'($urandom_range(0, 800));
            h = LEVEL_BITS'($urandom_range(1400, 2600));
            g = LEVEL_BITS'($urandom_range(3200, SAMPLE_MAX));
            mode = 1'b0;
         end
         1: begin
            l = LEVEL_BITS'($urandom);
            h = LEVEL_BITS'($urandom_range(0, 1200));
            g = LEVEL_BITS'($urandom_range(2000, SAMPLE_MAX));
            mode = 1'b1;
         end
         2: begin
            h = picks[$urandom_range(2)];
            l = picks[$urandom_range(2)];
            g = picks[$urandom_range(2)];
         end
         default: begin
            h = LEVEL_BITS'($urandom);
            l = LEVEL_BITS'($urandom);
            g = LEVEL_BITS'($urandom);
         end
      endcase
      program_cal(h, l, g, 1'($urandom_range(1)), mode);
   endtask

   // half the samples land next to a band edge of the current calibration
   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      int edges [8];
      int v;
      edges = '{sb.home + JOY_CENTRE_BAND, sb.home - JOY_CENTRE_BAND, sb.low + JOY_END_BAND,
                sb.high - JOY_END_BAND, sb.home + TRIG_LOW_BAND, sb.high - TRIG_HIGH_BAND,
                0, SAMPLE_MAX};
      if ($urandom_range(1) == 0)
         return SAMPLE_BITS'($urandom);
      v = edges[$urandom_range(7)] + $urandom_range(6) - 3;
      if (v < 0)
         v = 0;
      if (v > SAMPLE_MAX)
         v = SAMPLE_MAX;
      return v[SAMPLE_BITS-1:0];
   endfunction

   task automatic offer_sample(input logic [SAMPLE_BITS-1:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.sample <= s;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
   endtask

   // hold the sender until every response is back and the pipe is empty
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0)
         @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   initial begin
      int idle_sets [4][2];
      cal_count = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_toggle = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.sample = '0;
      idle_sets = '{'{0, 0}, '{70, 0}, '{0, 70}, '{13, 13}};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset calibration: everything at mid scale
      offer_sample(12'd0);
      offer_sample(12'd4095);
      offer_sample(12'd2047);
      drain();

      // joystick, around each band edge
      program_cal(12'd2048, 12'd100, 12'd4000, 1'b0, 1'b0);
      offer_sample(12'd250);
      offer_sample(12'd251);
      offer_sample(12'd1797);
      offer_sample(12'd1798);
      offer_sample(12'd2298);
      offer_sample(12'd2299);
      offer_sample(12'd3849);
      offer_sample(12'd3850);
      drain();
      program_cal(12'd2048, 12'd100, 12'd4000, 1'b1, 1'b0);
      offer_sample(12'd0);
      offer_sample(12'd1000);
      offer_sample(12'd4095);
      drain();

      // trigger axis
      program_cal(12'd300, 12'd0, 12'd4000, 1'b0, 1'b1);
      offer_sample(12'd500);
      offer_sample(12'd501);
      offer_sample(12'd3649);
      offer_sample(12'd3650);
      offer_sample(12'd4095);
      offer_sample(12'd0);
      drain();
      program_cal(12'd300, 12'd0, 12'd4000, 1'b1, 1'b1);
      offer_sample(12'd0);
      offer_sample(12'd2000);
      offer_sample(12'd4095);
      drain();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_sets[p][0];
         rsp_stall_pct = idle_sets[p][1];
         for (int c = 0; c < 8; c++) begin
            program_random_cal();
            for (int i = 0; i < 35; i++)
               offer_sample(pick_sample());
            drain();
         end
      end

      // long hold-off on the response side while requests keep coming
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      program_random_cal();
      hold_toggle <= ~hold_toggle;
      for (int i = 0; i < 40; i++)
         offer_sample(pick_sample());
      drain();

      repeat (2 * PIPE_LATENCY) @(posedge clock);
      $display("Checked %0d requests and %0d responses over %0d calibrations,",
               sb.requests, sb.responses, cal_count);
      $display("four idle patterns and one long response hold-off.");
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ analog_axis_deadzone_mapper_unit.f @@
hw/rtl/aadm_pkg.sv
hw/rtl/aadm_if.sv
hw/rtl/aadm_front.sv
hw/rtl/aadm_div_stage.sv
hw/rtl/aadm_back.sv
hw/rtl/analog_axis_deadzone_mapper_unit.sv
hw/rtl/aadm_checker.sv
dv/analog_axis_deadzone_mapper_unit_tb.sv
